// ----- hdl/pst_pkg.sv -----
package pst_pkg;

  // default limits
  localparam int unsigned            NEST_MAX_DEF = 255;
  localparam longint unsigned        LINE_MAX_DEF = 64'd65535;

  // character codes
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  localparam int unsigned LINE_OUT_W = 16;

  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_COMMENT = 6'b000010,
    MODE_STRING  = 6'b000100,
    MODE_ESCAPE  = 6'b001000,
    MODE_LEAD    = 6'b010000,
    MODE_BODY    = 6'b100000
  } mode_t;

  typedef enum logic [1:0] {
    ROLE_SKIP   = 2'd0,
    ROLE_DELIM  = 2'd1,
    ROLE_STRING = 2'd2,
    ROLE_NAME   = 2'd3
  } role_t;

  typedef struct packed {
    role_t role;
    logic  start;
    logic  done;
    logic  ended;
  } result_t;

endpackage

// ----- hdl/pst_step.sv -----
module pst_step #(
  parameter int unsigned     NEST_MAX = pst_pkg::NEST_MAX_DEF,
  parameter longint unsigned LINE_MAX = pst_pkg::LINE_MAX_DEF,
  parameter int unsigned     DEPTH_W  = 8,
  parameter int unsigned     LINE_W   = 16
) (
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  pst_pkg::mode_t     mode,
  input  logic [DEPTH_W-1:0] depth,
  input  logic [LINE_W-1:0]  line_cnt,
  input  logic               cr_seen,
  output pst_pkg::mode_t     mode_nxt,
  output logic [DEPTH_W-1:0] depth_nxt,
  output logic [LINE_W-1:0]  line_nxt,
  output logic               cr_nxt,
  output pst_pkg::result_t   res
);

  logic is_space;
  logic is_delim;
  logic ends_name;
  logic escaped;
  logic line_end;
  logic idle_hdl;

  assign is_space  = data_byte inside {[pst_pkg::CH_TAB:pst_pkg::CH_CR], pst_pkg::CH_SPACE};
  assign is_delim  = data_byte inside {pst_pkg::CH_LBRACK, pst_pkg::CH_RBRACK,
                                       pst_pkg::CH_LBRACE, pst_pkg::CH_RBRACE};
  assign ends_name = is_space || is_delim ||
                     data_byte inside {pst_pkg::CH_PERCENT, pst_pkg::CH_LPAREN};
  assign escaped   = (mode == pst_pkg::MODE_ESCAPE);

  // lf straight after a counted cr is part of the same line end
  assign line_end = !escaped && ((data_byte == pst_pkg::CH_CR) ||
                                 (data_byte == pst_pkg::CH_LF && !cr_seen));
  assign cr_nxt   = !escaped && (data_byte == pst_pkg::CH_CR);

  always_comb begin
    line_nxt = line_cnt;
    if (line_end && (line_cnt < LINE_W'(LINE_MAX))) begin
      line_nxt = line_cnt + LINE_W'(1);
    end
  end

  always_comb begin
    mode_nxt  = mode;
    depth_nxt = depth;
    res       = '{role: pst_pkg::ROLE_SKIP, start: 1'b0, done: 1'b0, ended: 1'b0};
    idle_hdl  = 1'b0;

    case (mode)
      pst_pkg::MODE_COMMENT: begin
        if (data_byte == pst_pkg::CH_CR || data_byte == pst_pkg::CH_LF) begin
          mode_nxt = pst_pkg::MODE_IDLE;
        end
      end
      pst_pkg::MODE_STRING: begin
        res.role = pst_pkg::ROLE_STRING;
        if (data_byte == pst_pkg::CH_BSLASH) begin
          mode_nxt = pst_pkg::MODE_ESCAPE;
        end else if (data_byte == pst_pkg::CH_LPAREN) begin
          if (depth < DEPTH_W'(NEST_MAX)) begin
            depth_nxt = depth + DEPTH_W'(1);
          end
        end else if (data_byte == pst_pkg::CH_RPAREN) begin
          if (depth == '0) begin
            res.done = 1'b1;
            mode_nxt = pst_pkg::MODE_IDLE;
          end else begin
            depth_nxt = depth - DEPTH_W'(1);
          end
        end
      end
      pst_pkg::MODE_ESCAPE: begin
        res.role = pst_pkg::ROLE_STRING;
        mode_nxt = pst_pkg::MODE_STRING;
      end
      pst_pkg::MODE_LEAD, pst_pkg::MODE_BODY: begin
        if (ends_name || (data_byte == pst_pkg::CH_SLASH && mode == pst_pkg::MODE_BODY)) begin
          res.ended = 1'b1;
          mode_nxt  = pst_pkg::MODE_IDLE;
          idle_hdl  = 1'b1;
        end else begin
          res.role = pst_pkg::ROLE_NAME;
          if (data_byte != pst_pkg::CH_SLASH) begin
            mode_nxt = pst_pkg::MODE_BODY;
          end
        end
      end
      default: begin
        mode_nxt = pst_pkg::MODE_IDLE;
        idle_hdl = 1'b1;
      end
    endcase

    if (idle_hdl) begin
      if (is_space) begin
        res.role = pst_pkg::ROLE_SKIP;
      end else if (data_byte == pst_pkg::CH_PERCENT) begin
        res.role = pst_pkg::ROLE_SKIP;
        mode_nxt = pst_pkg::MODE_COMMENT;
      end else if (is_delim) begin
        res.role  = pst_pkg::ROLE_DELIM;
        res.start = 1'b1;
        res.done  = 1'b1;
      end else if (data_byte == pst_pkg::CH_LPAREN) begin
        res.role  = pst_pkg::ROLE_STRING;
        res.start = 1'b1;
        depth_nxt = '0;
        mode_nxt  = pst_pkg::MODE_STRING;
      end else begin
        res.role  = pst_pkg::ROLE_NAME;
        res.start = 1'b1;
        mode_nxt  = (data_byte == pst_pkg::CH_SLASH) ? pst_pkg::MODE_LEAD
                                                     : pst_pkg::MODE_BODY;
      end
    end

    // open string or name is closed off by the end of text
    if (last_byte && (mode_nxt == pst_pkg::MODE_STRING || mode_nxt == pst_pkg::MODE_ESCAPE ||
                      mode_nxt == pst_pkg::MODE_LEAD || mode_nxt == pst_pkg::MODE_BODY)) begin
      res.done = 1'b1;
    end
  end

endmodule

// ----- hdl/postscript_encoding_tokenizer_unit.sv -----
// Streaming PostScript-style tokenizer: one text byte in, one role marking out per byte,
// at one byte per clock cycle sustained while out_tready stays high. Each byte passes
// the input register, then the result register; the scanner state (mode, string nesting
// depth, line count and CR-LF tracking) is updated once per byte by the step logic.
// A byte with in_tlast set closes any open string or name and returns all state to
// reset, so the next byte starts a fresh text. Nesting depth saturates at NEST_MAX,
// the line count at LINE_MAX; out line_number carries its low 16 bits.
module postscript_encoding_tokenizer_unit #(
  parameter int unsigned     NEST_MAX = pst_pkg::NEST_MAX_DEF,
  parameter longint unsigned LINE_MAX = pst_pkg::LINE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] token_start, [1] token_done,
                                  // [2] name_ended_before, [18:3] line_number, rest zero
  output logic [1:0]  out_tuser   // [1:0] byte_role
);

  localparam int unsigned DEPTH_W = $clog2(NEST_MAX + 1);
  localparam int unsigned LINE_W  = $clog2(LINE_MAX + 64'd1);

  logic               in_vld_r;
  logic [7:0]         in_data_r;
  logic               in_last_r;
  logic               advance;

  pst_pkg::mode_t     mode_r, mode_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;
  logic               cr_r, cr_nxt;
  pst_pkg::result_t   res;

  logic               out_vld_r;
  pst_pkg::result_t   out_res_r;
  logic [15:0]        out_line_r;
  logic [15:0]        line_out;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  pst_step #(
    .NEST_MAX (NEST_MAX),
    .LINE_MAX (LINE_MAX),
    .DEPTH_W  (DEPTH_W),
    .LINE_W   (LINE_W)
  ) u_step (
    .data_byte (in_data_r),
    .last_byte (in_last_r),
    .mode      (mode_r),
    .depth     (depth_r),
    .line_cnt  (line_r),
    .cr_seen   (cr_r),
    .mode_nxt  (mode_nxt),
    .depth_nxt (depth_nxt),
    .line_nxt  (line_nxt),
    .cr_nxt    (cr_nxt),
    .res       (res)
  );

  generate
    if (LINE_W >= 16) begin : g_line_wide
      assign line_out = line_nxt[15:0];
    end else begin : g_line_narrow
      assign line_out = {{(16 - LINE_W){1'b0}}, line_nxt};
    end
  endgenerate

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= pst_pkg::MODE_IDLE;
      depth_r <= '0;
      line_r  <= LINE_W'(1);
      cr_r    <= 1'b0;
    end else if (advance) begin
      if (in_last_r) begin
        mode_r  <= pst_pkg::MODE_IDLE;
        depth_r <= '0;
        line_r  <= LINE_W'(1);
        cr_r    <= 1'b0;
      end else begin
        mode_r  <= mode_nxt;
        depth_r <= depth_nxt;
        line_r  <= line_nxt;
        cr_r    <= cr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r  <= res;
      out_line_r <= line_out;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.role;
  assign out_tdata  = {5'b0, out_line_r, out_res_r.ended, out_res_r.done, out_res_r.start};

endmodule

// ----- tb/sv/token_mark_checker.sv -----
`timescale 1ns / 100ps

module token_mark_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [0] token_start, [1] token_done,
                                  // [2] name_ended_before, [18:3] line_number
  input  logic [1:0]  out_tuser,  // [1:0] byte_role
  output int          mismatches,
  output int          marks_pending
);

  typedef struct packed {
    pst_pkg::role_t role;
    logic           start;
    logic           done;
    logic           ended;
    logic [15:0]    line;
  } mark_t;

  mark_t           marks_due[$];
  pst_pkg::mode_t  scan_st;
  int unsigned     depth;
  longint unsigned lines;
  logic            cr_seen;

  function automatic logic is_blank(input logic [7:0] c);
    return c == pst_pkg::CH_SPACE || (c >= pst_pkg::CH_TAB && c <= pst_pkg::CH_CR);
  endfunction

  function automatic logic is_bracket(input logic [7:0] c);
    return c == pst_pkg::CH_LBRACK || c == pst_pkg::CH_RBRACK ||
           c == pst_pkg::CH_LBRACE || c == pst_pkg::CH_RBRACE;
  endfunction

  function automatic void clear_scan();
    scan_st = pst_pkg::MODE_IDLE;
    depth   = 0;
    lines   = 1;
    cr_seen = 1'b0;
  endfunction

  function automatic void count_line();
    if (lines < pst_pkg::LINE_MAX_DEF) lines++;
  endfunction

  // role marking of one text byte, advancing the scan state
  function automatic mark_t mark_byte(input logic [7:0] c, input logic last);
    mark_t m;
    logic  esc;
    logic  rescan;
    m      = '0;
    m.role = pst_pkg::ROLE_SKIP;
    esc    = (scan_st == pst_pkg::MODE_ESCAPE);
    rescan = 1'b0;

    if (!esc) begin
      if (c == pst_pkg::CH_LF) begin
        if (!cr_seen) count_line();
      end else if (c == pst_pkg::CH_CR) begin
        count_line();
      end
    end
    cr_seen = !esc && c == pst_pkg::CH_CR;

    case (scan_st)
      pst_pkg::MODE_COMMENT: begin
        if (c == pst_pkg::CH_CR || c == pst_pkg::CH_LF) scan_st = pst_pkg::MODE_IDLE;
      end
      pst_pkg::MODE_STRING: begin
        m.role = pst_pkg::ROLE_STRING;
        if (c == pst_pkg::CH_BSLASH) begin
          scan_st = pst_pkg::MODE_ESCAPE;
        end else if (c == pst_pkg::CH_LPAREN) begin
          if (depth < pst_pkg::NEST_MAX_DEF) depth++;
        end else if (c == pst_pkg::CH_RPAREN) begin
          if (depth == 0) begin
            m.done  = 1'b1;
            scan_st = pst_pkg::MODE_IDLE;
          end else begin
            depth--;
          end
        end
      end
      pst_pkg::MODE_ESCAPE: begin
        m.role  = pst_pkg::ROLE_STRING;
        scan_st = pst_pkg::MODE_STRING;
      end
      pst_pkg::MODE_LEAD, pst_pkg::MODE_BODY: begin
        if (is_blank(c) || is_bracket(c) || c == pst_pkg::CH_PERCENT ||
            c == pst_pkg::CH_LPAREN ||
            (c == pst_pkg::CH_SLASH && scan_st == pst_pkg::MODE_BODY)) begin
          m.ended = 1'b1;
          rescan  = 1'b1;
        end else begin
          m.role = pst_pkg::ROLE_NAME;
          if (c != pst_pkg::CH_SLASH) scan_st = pst_pkg::MODE_BODY;
        end
      end
      default: rescan = 1'b1;
    endcase

    // byte seen as between tokens
    if (rescan) begin
      scan_st = pst_pkg::MODE_IDLE;
      if (is_blank(c)) begin
        m.role = pst_pkg::ROLE_SKIP;
      end else if (c == pst_pkg::CH_PERCENT) begin
        m.role  = pst_pkg::ROLE_SKIP;
        scan_st = pst_pkg::MODE_COMMENT;
      end else if (is_bracket(c)) begin
        m.role  = pst_pkg::ROLE_DELIM;
        m.start = 1'b1;
        m.done  = 1'b1;
      end else if (c == pst_pkg::CH_LPAREN) begin
        m.role  = pst_pkg::ROLE_STRING;
        m.start = 1'b1;
        depth   = 0;
        scan_st = pst_pkg::MODE_STRING;
      end else begin
        m.role  = pst_pkg::ROLE_NAME;
        m.start = 1'b1;
        scan_st = (c == pst_pkg::CH_SLASH) ? pst_pkg::MODE_LEAD : pst_pkg::MODE_BODY;
      end
    end

    if (last && (scan_st == pst_pkg::MODE_STRING || scan_st == pst_pkg::MODE_ESCAPE ||
                 scan_st == pst_pkg::MODE_LEAD || scan_st == pst_pkg::MODE_BODY))
      m.done = 1'b1;

    m.line = lines[15:0];
    if (last) clear_scan();
    return m;
  endfunction

  initial begin
    mismatches    = 0;
    marks_pending = 0;
    clear_scan();
  end

  always @(posedge clk) begin
    mark_t want;
    mark_t got;
    if (!rst_n) begin
      marks_due.delete();
      clear_scan();
    end else begin
      if (in_tvalid && in_tready) marks_due.push_back(mark_byte(in_tdata, in_tlast));
      if (out_tvalid && out_tready) begin
        got.role  = pst_pkg::role_t'(out_tuser);
        got.start = out_tdata[0];
        got.done  = out_tdata[1];
        got.ended = out_tdata[2];
        got.line  = out_tdata[18:3];
        if (marks_due.size() == 0) begin
          if (mismatches < 100)
            $display("%0t: unexpected item role=%0d start=%0b done=%0b ended=%0b line=%0d",
                     $time, got.role, got.start, got.done, got.ended, got.line);
          mismatches++;
        end else begin
          want = marks_due.pop_front();
          if (want != got || out_tdata[23:19] != '0) begin
            if (mismatches < 100)
              $display({"%0t: mismatch expected role=%0d start=%0b done=%0b ended=%0b ",
                        "line=%0d pad=0, actual role=%0d start=%0b done=%0b ended=%0b ",
                        "line=%0d pad=%0h"},
                       $time, want.role, want.start, want.done, want.ended, want.line,
                       got.role, got.start, got.done, got.ended, got.line,
                       out_tdata[23:19]);
            mismatches++;
          end
        end
      end
    end
    marks_pending = marks_due.size();
  end

endmodule

// ----- tb/sv/postscript_encoding_tokenizer_unit_tb.sv -----
`timescale 1ns / 100ps

module postscript_encoding_tokenizer_unit_tb;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tlast;   // last_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [0] token_start, [1] token_done,
                           // [2] name_ended_before, [18:3] line_number, rest zero
  logic [1:0]  out_tuser;  // [1:0] byte_role

  int mismatches;
  int marks_pending;
  int idle_pct;
  int stall_pct;
  int hold_req;
  int hold_left;
  int bytes_sent;

  postscript_encoding_tokenizer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  token_mark_checker u_marks (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .mismatches    (mismatches),
    .marks_pending (marks_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_tready = 1'b0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_req  = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // called just after a falling edge, returns just after the falling edge following acceptance
  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // text byte that now and then ends the text mid-token
  task automatic send_char(input logic [7:0] b);
    send_byte(b, $urandom_range(99) < 2);
  endtask

  task automatic send_line_end();
    case ($urandom_range(2))
      0: send_char(pst_pkg::CH_LF);
      1: send_char(pst_pkg::CH_CR);
      default: begin
        send_char(pst_pkg::CH_CR);
        send_char(pst_pkg::CH_LF);
      end
    endcase
  endtask

  task automatic send_token();
    logic [7:0] c;
    int         nest;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      repeat ($urandom_range(1, 4))
        case ($urandom_range(2))
          0: send_char(pst_pkg::CH_SPACE);
          1: send_char(8'($urandom_range(9, 12)));
          default: send_line_end();
        endcase
    end else if (pick < 25) begin
      send_char(pst_pkg::CH_PERCENT);
      repeat ($urandom_range(0, 8)) send_char(8'($urandom_range(14, 255)));
      send_line_end();
    end else if (pick < 40) begin
      case ($urandom_range(3))
        0: send_char(pst_pkg::CH_LBRACK);
        1: send_char(pst_pkg::CH_RBRACK);
        2: send_char(pst_pkg::CH_LBRACE);
        default: send_char(pst_pkg::CH_RBRACE);
      endcase
    end else if (pick < 65) begin
      nest = 0;
      send_char(pst_pkg::CH_LPAREN);
      repeat ($urandom_range(1, 12))
        case ($urandom_range(9))
          0: begin
            send_char(pst_pkg::CH_LPAREN);
            nest++;
          end
          1: begin
            if (nest > 0) begin
              send_char(pst_pkg::CH_RPAREN);
              nest--;
            end else begin
              send_char("s");
            end
          end
          2: begin
            send_char(pst_pkg::CH_BSLASH);
            send_char(8'($urandom_range(255)));
          end
          3: begin
            send_char(pst_pkg::CH_BSLASH);
            send_char($urandom_range(1) ? pst_pkg::CH_CR : pst_pkg::CH_LF);
          end
          4: send_line_end();
          default: begin
            c = 8'($urandom_range(255));
            if (c == pst_pkg::CH_LPAREN || c == pst_pkg::CH_RPAREN ||
                c == pst_pkg::CH_BSLASH) c = "z";
            send_char(c);
          end
        endcase
      repeat (nest + 1) send_char(pst_pkg::CH_RPAREN);
    end else if (pick < 90) begin
      // name: leading slashes then body; the next token often ends it directly
      repeat ($urandom_range(0, 3)) send_char(pst_pkg::CH_SLASH);
      repeat ($urandom_range(1, 8)) begin
        c = 8'($urandom_range(255));
        if (c < 8'h30 || (c >= pst_pkg::CH_LBRACK && c <= pst_pkg::CH_RBRACK) ||
            c == pst_pkg::CH_LBRACE || c == pst_pkg::CH_RBRACE)
          c = c | 8'h80;
        send_char(c);
      end
    end else if (pick < 95) begin
      send_char($urandom_range(1) ? pst_pkg::CH_RPAREN : pst_pkg::CH_BSLASH);
    end else begin
      send_char(8'($urandom_range(255)));
    end
  endtask

  task automatic drain_marks();
    in_tvalid <= 1'b0;
    while (marks_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int first;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_req   = 0;
    bytes_sent = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // delimiters, names broken by slashes, extreme body bytes
    send_byte(pst_pkg::CH_LBRACK, 1'b0);
    send_byte(pst_pkg::CH_RBRACK, 1'b0);
    send_byte(pst_pkg::CH_LBRACE, 1'b0);
    send_byte(pst_pkg::CH_RBRACE, 1'b0);
    send_byte(pst_pkg::CH_SPACE, 1'b0);
    send_byte(pst_pkg::CH_SLASH, 1'b0);
    send_byte(pst_pkg::CH_SLASH, 1'b0);
    send_byte("a", 1'b0);
    send_byte(pst_pkg::CH_SLASH, 1'b0);
    send_byte("b", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // string right after a name, escaped CR inside
    send_byte(pst_pkg::CH_LPAREN, 1'b0);
    send_byte(pst_pkg::CH_BSLASH, 1'b0);
    send_byte(pst_pkg::CH_CR, 1'b0);
    send_byte(pst_pkg::CH_RPAREN, 1'b0);
    send_byte(pst_pkg::CH_CR, 1'b0);
    send_byte(pst_pkg::CH_LF, 1'b0);
    send_byte(pst_pkg::CH_PERCENT, 1'b0);
    send_byte("x", 1'b0);
    send_byte(pst_pkg::CH_LF, 1'b0);
    // stray close paren starts a name
    send_byte(pst_pkg::CH_RPAREN, 1'b0);
    send_byte(pst_pkg::CH_TAB, 1'b0);
    // text ends inside an open string
    send_byte(pst_pkg::CH_LPAREN, 1'b0);
    send_byte("q", 1'b1);
    drain_marks();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      first = bytes_sent;
      while (bytes_sent - first < 170) send_token();
      drain_marks();
    end

    // receiver holds off while bytes keep coming, so the input backs up
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1;
    first = bytes_sent;
    while (bytes_sent - first < 200) send_token();
    drain_marks();

    // nesting saturates, then unwinds to the closing paren
    send_byte(pst_pkg::CH_LPAREN, 1'b0);
    repeat (300) send_byte(pst_pkg::CH_LPAREN, 1'b0);
    repeat (255) send_byte(pst_pkg::CH_RPAREN, 1'b0);
    send_byte(pst_pkg::CH_RPAREN, 1'b0);
    send_byte(pst_pkg::CH_SPACE, 1'b0);

    // a few line ends; the next text starts again at line one
    repeat (3) send_byte(pst_pkg::CH_LF, 1'b0);
    send_byte("x", 1'b1);
    send_byte("y", 1'b1);
    drain_marks();

    repeat (8) @(negedge clk);
    if (mismatches == 0 && marks_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/pst_pkg.sv
hdl/pst_step.sv
hdl/postscript_encoding_tokenizer_unit.sv
tb/sv/token_mark_checker.sv
tb/sv/postscript_encoding_tokenizer_unit_tb.sv
